FILE: sv/gasp_pkg.sv
// glyph atlas shelf packer: shared constants, types and status codes
// no dependencies; imported by gasp_scan, the top level and the sim files
`timescale 1ns / 1ps

package gasp_pkg;

   localparam int MAX_SHELVES   = 64;
   localparam int INITIAL_ATLAS = 128;
   localparam int MAX_ATLAS_RST = 4096;

   localparam int SHELF_IDX_W = $clog2(MAX_SHELVES);
   localparam int COUNT_W     = $clog2(MAX_SHELVES + 1);

   localparam int GLYPH_W   = 12;
   localparam int POS_W     = 14;
   localparam int ATLAS_W   = 15;
   localparam int SHELF_H_W = 13;
   localparam int TEN_H_W   = 16;

   // floor(h / 10) as (h * 3277) >> 15, exact for 12-bit h
   localparam int TENTH_MUL   = 3277;
   localparam int TENTH_SHIFT = 15;
   localparam int TENTH_PROD_W = 24;

   localparam logic [GLYPH_W-1:0] FAIL_SIZE = GLYPH_W'(2);

   typedef enum logic [1:0] {
      ST_PLACED     = 2'd0,
      ST_ATLAS_MAX  = 2'd1,
      ST_TABLE_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [ATLAS_W-1:0]   top;
      logic [SHELF_H_W-1:0] height;
      logic [ATLAS_W-1:0]   fill;
   } shelf_entry_type;

   localparam int ENTRY_W = $bits(shelf_entry_type);

   typedef struct packed {
      logic                   found;
      logic [SHELF_IDX_W-1:0] idx;
      shelf_entry_type        entry;
   } scan_res_type;

endpackage

FILE: sv/gasp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module gasp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/gasp_scan.sv
// shelf scan unit: tests each shelf read from the table and keeps the best fit
// depends on gasp_pkg
`timescale 1ns / 1ps

module gasp_scan
   import gasp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   rd_valid,
   input  logic [SHELF_IDX_W-1:0] rd_idx,
   input  shelf_entry_type        rd_entry,
   input  logic [GLYPH_W-1:0]     glyph_w,
   input  logic [GLYPH_W-1:0]     glyph_h,
   input  logic [TEN_H_W-1:0]     ten_h,
   input  logic [ATLAS_W-1:0]     atlas,
   output scan_res_type           result
);

   logic                   found_ff;
   logic [SHELF_IDX_W-1:0] best_idx_ff;
   shelf_entry_type        best_entry_ff;

   logic [TEN_H_W-1:0] seven_sh;
   logic [ATLAS_W:0]   fill_end;
   logic               height_ok;
   logic               room_ok;
   logic               better;
   logic               take;

   always_comb begin
      seven_sh  = (TEN_H_W'(rd_entry.height) << 3) - TEN_H_W'(rd_entry.height);
      fill_end  = {1'b0, rd_entry.fill} + (ATLAS_W + 1)'(glyph_w);
      height_ok = (ten_h >= seven_sh) && (SHELF_H_W'(glyph_h) <= rd_entry.height);
      room_ok   = (rd_entry.fill <= atlas) && (fill_end <= {1'b0, atlas});
      // lowest shelf wins, later row wins ties
      better    = !found_ff || (rd_entry.height <= best_entry_ff.height);
      take      = rd_valid && height_ok && room_ok && better;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= rd_idx;
         best_entry_ff <= rd_entry;
      end
   end

   assign result.found = found_ff;
   assign result.idx   = best_idx_ff;
   assign result.entry = best_entry_ff;

endmodule

FILE: sv/glyph_atlas_shelf_packer.sv
// glyph atlas shelf packer top level: sequencer, atlas growth, result register
// depends on gasp_pkg, gasp_ram, gasp_scan
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  glyph width, glyph height
// rsp_      out        rsp_valid / rsp_stall  rect x/y/w/h, status, atlas edge
// csr_      in         csr_wr_en              max atlas size
//
// one item at a time; after the accept the one-read-per-cycle table scan reads every
// row below the shelf count, a decide step places the glyph on the chosen shelf, fails
// on a full table or goes on to a grow step that doubles the atlas as needed and opens a new shelf
// the next item is taken the cycle after its result enters the output register
// reset zeroes shelf count and next shelf top, sets the atlas to 128 and the max
// to 4096; the table itself is not cleared, only rows below the count are read
// a waiting result sits in the output register while the next item is scanned

module glyph_atlas_shelf_packer
   import gasp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [GLYPH_W-1:0] req_glyph_width,
   input  logic [GLYPH_W-1:0] req_glyph_height,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [POS_W-1:0]   rsp_rect_x,
   output logic [POS_W-1:0]   rsp_rect_y,
   output logic [GLYPH_W-1:0] rsp_rect_w,
   output logic [GLYPH_W-1:0] rsp_rect_h,
   output logic [1:0]         rsp_status,
   output logic [ATLAS_W-1:0] rsp_atlas_edge,
   input  logic               csr_wr_en,
   input  logic [ATLAS_W-1:0] csr_wr_data
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_GROW   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ATLAS_W-1:0] next_top_ff, next_top_in;
   logic [ATLAS_W-1:0] atlas_ff, atlas_in;
   logic [ATLAS_W-1:0] max_atlas_ff, max_atlas_in;
   logic [COUNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [SHELF_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-item operands
   logic [GLYPH_W-1:0]   w_ff, w_in;
   logic [GLYPH_W-1:0]   h_ff, h_in;
   logic [SHELF_H_W-1:0] rh_ff, rh_in;
   logic [TEN_H_W-1:0]   ten_h_ff, ten_h_in;

   // finished result, waiting for the output register
   logic [POS_W-1:0]   res_x_ff, res_x_in;
   logic [POS_W-1:0]   res_y_ff, res_y_in;
   logic [GLYPH_W-1:0] res_w_ff, res_w_in;
   logic [GLYPH_W-1:0] res_h_ff, res_h_in;
   logic [1:0]         res_status_ff, res_status_in;

   // output register
   logic [POS_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]   rsp_y_ff, rsp_y_in;
   logic [GLYPH_W-1:0] rsp_w_ff, rsp_w_in;
   logic [GLYPH_W-1:0] rsp_h_ff, rsp_h_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [ATLAS_W-1:0] rsp_edge_ff, rsp_edge_in;

   // table ram ports
   logic                   ram_wr_en;
   logic [SHELF_IDX_W-1:0] ram_wr_addr;
   shelf_entry_type        ram_wr_entry;
   logic                   ram_rd_en;
   logic [ENTRY_W-1:0]     ram_rd_data;
   shelf_entry_type        rd_entry;

   scan_res_type           scan_res;

   logic                    accept;
   logic [TENTH_PROD_W-1:0] tenth_prod;
   logic [ATLAS_W:0]        new_bottom;
   logic [ATLAS_W:0]        doubled;
   logic                    need_grow;
   logic [ATLAS_W:0]        best_fill_end;
   logic                    out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rd_entry  = shelf_entry_type'(ram_rd_data);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   gasp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SHELVES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff[SHELF_IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   gasp_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (accept),
      .rd_valid (rd_valid_ff),
      .rd_idx   (rd_idx_ff),
      .rd_entry (rd_entry),
      .glyph_w  (w_ff),
      .glyph_h  (h_ff),
      .ten_h    (ten_h_ff),
      .atlas    (atlas_ff),
      .result   (scan_res)
   );

   always_comb begin
      // new shelf height h + floor(h/10), tenth by reciprocal multiply
      tenth_prod = TENTH_PROD_W'(req_glyph_height) * TENTH_PROD_W'(TENTH_MUL);
      new_bottom = {1'b0, next_top_ff} + (ATLAS_W + 1)'(rh_ff);
      doubled    = {atlas_ff, 1'b0};
      need_grow  = (new_bottom >= {1'b0, atlas_ff}) || (ATLAS_W'(w_ff) >= atlas_ff);
      best_fill_end = {1'b0, scan_res.entry.fill} + (ATLAS_W + 1)'(w_ff);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_top_in   = next_top_ff;
      atlas_in      = atlas_ff;
      max_atlas_in  = max_atlas_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = scan_idx_ff[SHELF_IDX_W-1:0];
      w_in          = w_ff;
      h_in          = h_ff;
      rh_in         = rh_ff;
      ten_h_in      = ten_h_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_w_in      = res_w_ff;
      res_h_in      = res_h_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_status_in = rsp_status_ff;
      rsp_edge_in   = rsp_edge_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = scan_res.idx;
      ram_wr_entry  = scan_res.entry;
      ram_rd_en     = 1'b0;

      // the user must write this register only while idle; the block itself does not enforce it
      if (csr_wr_en) begin
         max_atlas_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               w_in        = req_glyph_width;
               h_in        = req_glyph_height;
               rh_in       = SHELF_H_W'(req_glyph_height)
                           + SHELF_H_W'(tenth_prod >> TENTH_SHIFT);
               ten_h_in    = (TEN_H_W'(req_glyph_height) << 3)
                           + (TEN_H_W'(req_glyph_height) << 1);
               scan_idx_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // one row read per cycle, tested the cycle after
            if (scan_idx_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               scan_idx_in = scan_idx_ff + COUNT_W'(1);
            end else if (!rd_valid_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (scan_res.found) begin
               // place on the chosen shelf and advance its fill
               ram_wr_en         = 1'b1;
               ram_wr_addr       = scan_res.idx;
               ram_wr_entry      = scan_res.entry;
               ram_wr_entry.fill = best_fill_end[ATLAS_W-1:0];
               res_x_in          = scan_res.entry.fill[POS_W-1:0];
               res_y_in          = scan_res.entry.top[POS_W-1:0];
               res_w_in          = w_ff;
               res_h_in          = h_ff;
               res_status_in     = ST_PLACED;
               state_in          = S_DONE;
            end else if (count_ff == COUNT_W'(MAX_SHELVES)) begin
               res_x_in      = '0;
               res_y_in      = '0;
               res_w_in      = FAIL_SIZE;
               res_h_in      = FAIL_SIZE;
               res_status_in = ST_TABLE_FULL;
               state_in      = S_DONE;
            end else begin
               state_in = S_GROW;
            end
         end
         S_GROW: begin
            if (need_grow) begin
               // one doubling per cycle; doublings already done are kept on failure
               if (doubled <= {1'b0, max_atlas_ff}) begin
                  atlas_in = doubled[ATLAS_W-1:0];
               end else begin
                  res_x_in      = '0;
                  res_y_in      = '0;
                  res_w_in      = FAIL_SIZE;
                  res_h_in      = FAIL_SIZE;
                  res_status_in = ST_ATLAS_MAX;
                  state_in      = S_DONE;
               end
            end else begin
               // open a new shelf at the next free top, glyph at its left edge
               ram_wr_en           = 1'b1;
               ram_wr_addr         = count_ff[SHELF_IDX_W-1:0];
               ram_wr_entry.top    = next_top_ff;
               ram_wr_entry.height = rh_ff;
               ram_wr_entry.fill   = ATLAS_W'(w_ff);
               count_in            = count_ff + COUNT_W'(1);
               next_top_in         = new_bottom[ATLAS_W-1:0];
               res_x_in            = '0;
               res_y_in            = next_top_ff[POS_W-1:0];
               res_w_in            = w_ff;
               res_h_in            = h_ff;
               res_status_in       = ST_PLACED;
               state_in            = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               rsp_w_in      = res_w_ff;
               rsp_h_in      = res_h_ff;
               rsp_status_in = res_status_ff;
               rsp_edge_in   = atlas_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_top_ff  <= '0;
         atlas_ff     <= ATLAS_W'(INITIAL_ATLAS);
         max_atlas_ff <= ATLAS_W'(MAX_ATLAS_RST);
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_top_ff  <= next_top_in;
         atlas_ff     <= atlas_in;
         max_atlas_ff <= max_atlas_in;
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      rh_ff         <= rh_in;
      ten_h_ff      <= ten_h_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_w_ff      <= res_w_in;
      res_h_ff      <= res_h_in;
      res_status_ff <= res_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_status_ff <= rsp_status_in;
      rsp_edge_ff   <= rsp_edge_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rect_x     = rsp_x_ff;
   assign rsp_rect_y     = rsp_y_ff;
   assign rsp_rect_w     = rsp_w_ff;
   assign rsp_rect_h     = rsp_h_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_atlas_edge = rsp_edge_ff;

   // the atlas only ever grows between resets
   a_atlas_monotone: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (atlas_ff >= $past(atlas_ff)))
      else $error("atlas edge shrank");

   // at most one shelf is opened per cycle, and never past the table size
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((count_ff == $past(count_ff))
             || ((count_ff == $past(count_ff) + COUNT_W'(1))
                 && (count_ff <= COUNT_W'(MAX_SHELVES)))))
      else $error("shelf count stepped wrongly");

   // a table write never overlaps a scan read
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && (ram_rd_en || rd_valid_ff)))
      else $error("table write during scan");

   // the input side is closed whenever an item is in flight
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff || ram_wr_en) |-> req_stall)
      else $error("input open while busy");

endmodule

FILE: sim/shelf_placement_checker.sv
// placement checker for the glyph atlas shelf packer: predicts every rect
// from the accepted requests and compares it with the returned items
// depends on gasp_pkg; instantiated by tb beside the block
`timescale 1ns / 1ps

module shelf_placement_checker
   import gasp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [GLYPH_W-1:0] req_glyph_width,
   input  logic [GLYPH_W-1:0] req_glyph_height,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [POS_W-1:0]   rsp_rect_x,
   input  logic [POS_W-1:0]   rsp_rect_y,
   input  logic [GLYPH_W-1:0] rsp_rect_w,
   input  logic [GLYPH_W-1:0] rsp_rect_h,
   input  logic [1:0]         rsp_status,
   input  logic [ATLAS_W-1:0] rsp_atlas_edge,
   input  logic               csr_wr_en,
   input  logic [ATLAS_W-1:0] csr_wr_data,
   output int unsigned        fail_count,
   output int unsigned        outstanding
);

   typedef struct packed {
      logic [POS_W-1:0]   rect_x;
      logic [POS_W-1:0]   rect_y;
      logic [GLYPH_W-1:0] rect_w;
      logic [GLYPH_W-1:0] rect_h;
      status_type         status;
      logic [ATLAS_W-1:0] atlas_edge;
   } placement_type;

   placement_type placement_q [$];

   // shadow of the shelf table and atlas state
   logic [ATLAS_W-1:0]   row_top  [MAX_SHELVES];
   logic [SHELF_H_W-1:0] shelf_ht [MAX_SHELVES];
   logic [ATLAS_W-1:0]   row_fill [MAX_SHELVES];
   logic [COUNT_W-1:0]   rows_used;
   logic [ATLAS_W-1:0]   open_top;
   logic [ATLAS_W-1:0]   cur_edge;
   logic [ATLAS_W-1:0]   edge_limit;

   function automatic placement_type place_glyph(input logic [GLYPH_W-1:0] gw,
                                                 input logic [GLYPH_W-1:0] gh);
      int unsigned   wi, hi, sh, rh, px, grown;
      int            pick;
      bit            found;
      placement_type res;
      wi    = 32'(gw);
      hi    = 32'(gh);
      grown = 32'(cur_edge);
      pick  = 0;
      found = 1'b0;
      res.rect_x = '0;
      res.rect_y = '0;
      res.rect_w = FAIL_SIZE;
      res.rect_h = FAIL_SIZE;
      // lowest fitting shelf, later row wins ties
      for (int i = 0; i < rows_used; i++) begin
         sh = 32'(shelf_ht[i]);
         if (10 * hi >= 7 * sh && hi <= sh && 32'(row_fill[i]) <= grown &&
             wi <= grown - 32'(row_fill[i]) && !(found && sh > 32'(shelf_ht[pick]))) begin
            pick  = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         if (rows_used >= MAX_SHELVES) begin
            res.status     = ST_TABLE_FULL;
            res.atlas_edge = cur_edge;
            return res;
         end
         rh = hi + hi / 10;
         while (32'(open_top) + rh >= grown || wi >= grown) begin
            if (grown * 2 <= 32'(edge_limit)) begin
               grown = grown * 2;
            end else begin
               // doubling done so far is kept
               cur_edge       = ATLAS_W'(grown);
               res.status     = ST_ATLAS_MAX;
               res.atlas_edge = cur_edge;
               return res;
            end
         end
         cur_edge       = ATLAS_W'(grown);
         pick           = int'(rows_used);
         row_top[pick]  = open_top;
         shelf_ht[pick] = SHELF_H_W'(rh);
         row_fill[pick] = '0;
         rows_used      = rows_used + COUNT_W'(1);
         open_top       = ATLAS_W'(32'(open_top) + rh);
      end
      px             = 32'(row_fill[pick]);
      row_fill[pick] = ATLAS_W'(px + wi);
      res.rect_x     = POS_W'(px);
      res.rect_y     = row_top[pick][POS_W-1:0];
      res.rect_w     = gw;
      res.rect_h     = gh;
      res.status     = ST_PLACED;
      res.atlas_edge = cur_edge;
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         rows_used  = '0;
         open_top   = '0;
         cur_edge   = ATLAS_W'(INITIAL_ATLAS);
         edge_limit = ATLAS_W'(MAX_ATLAS_RST);
         placement_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (placement_q.size() == 0) begin
               $display("%0t: unexpected item, expected none actual x=%0d y=%0d status=%0d",
                        $time, rsp_rect_x, rsp_rect_y, rsp_status);
               fail_count++;
            end else begin
               want = placement_q.pop_front();
               check_field("rect_x", 32'(want.rect_x), 32'(rsp_rect_x));
               check_field("rect_y", 32'(want.rect_y), 32'(rsp_rect_y));
               check_field("rect_w", 32'(want.rect_w), 32'(rsp_rect_w));
               check_field("rect_h", 32'(want.rect_h), 32'(rsp_rect_h));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("atlas_edge", 32'(want.atlas_edge), 32'(rsp_atlas_edge));
            end
         end
         if (csr_wr_en)
            edge_limit = csr_wr_data;
         if (req_valid && !req_stall) begin
            want = place_glyph(req_glyph_width, req_glyph_height);
            placement_q.insert(placement_q.size(), want);
         end
      end
      outstanding = placement_q.size();
   end

endmodule

FILE: sim/tb.sv
// top of the glyph atlas shelf packer testbench: clock, reset, stimulus and verdict
// depends on gasp_pkg, glyph_atlas_shelf_packer and shelf_placement_checker
`timescale 1ns / 1ps

module tb
   import gasp_pkg::*;
();

   // run limit, several times the slowest legal run
   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int unsigned PHASE_ITEMS     = 247;
   localparam int unsigned PRESSURE_AT     = 300;
   localparam int unsigned PRESSURE_CYCLES = 400;
   localparam int unsigned END_SETTLE      = 100;

   // growth limits per phase, phase 0 is the rightmost entry
   localparam logic [4:0][ATLAS_W-1:0] PHASE_LIMIT =
      {15'd4096, 15'd32767, 15'd3000, 15'd16384, 15'd128};

   // corner values for the glyph fields
   localparam logic [3:0][GLYPH_W-1:0] CORNER_SIZE = {12'd4095, 12'd2048, 12'd1, 12'd0};

   // opening items {width, height}, run from the leftmost entry down, all at the
   // reset growth limit; atlas starts at 128 and each line notes the intent
   localparam logic [15:0][2*GLYPH_W-1:0] OPENING = {
      {12'd0,    12'd0},      // zero height opens a zero height shelf
      {12'd7,    12'd0},      // zero height joins the zero height shelf
      {12'd0,    12'd5},      // zero width, new shelf of 5
      {12'd0,    12'd5},      // zero width fits that shelf
      {12'd10,   12'd20},     // shelf of 22
      {12'd10,   12'd20},     // same shelf, advances the fill
      {12'd10,   12'd16},     // lower bound of the height test
      {12'd100,  12'd20},     // too wide for the rest, second shelf of 22
      {12'd5,    12'd18},     // two equal shelves, the later one wins
      {12'd120,  12'd19},     // neither fits, shelf of 20
      {12'd3,    12'd19},     // lowest of three candidates wins
      {12'd128,  12'd1},      // width forces one doubling
      {12'd1,    12'd200},    // height forces a doubling
      {12'd4095, 12'd4095},   // several doublings, then atlas at limit
      {12'd4095, 12'd1},      // widest glyph still placed
      {12'd1,    12'd4095}    // tallest glyph, atlas at limit
   };

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [GLYPH_W-1:0] req_glyph_width  = '0;
   logic [GLYPH_W-1:0] req_glyph_height = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [POS_W-1:0]   rsp_rect_x;
   logic [POS_W-1:0]   rsp_rect_y;
   logic [GLYPH_W-1:0] rsp_rect_w;
   logic [GLYPH_W-1:0] rsp_rect_h;
   logic [1:0]         rsp_status;
   logic [ATLAS_W-1:0] rsp_atlas_edge;
   logic               csr_wr_en        = 1'b0;
   logic [ATLAS_W-1:0] csr_wr_data      = '0;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned cycles;
   int unsigned items_sent;

   glyph_atlas_shelf_packer dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_glyph_width,
      .req_glyph_height,
      .rsp_valid,
      .rsp_stall,
      .rsp_rect_x,
      .rsp_rect_y,
      .rsp_rect_w,
      .rsp_rect_h,
      .rsp_status,
      .rsp_atlas_edge,
      .csr_wr_en,
      .csr_wr_data
   );

   shelf_placement_checker u_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_glyph_width,
      .req_glyph_height,
      .rsp_valid,
      .rsp_stall,
      .rsp_rect_x,
      .rsp_rect_y,
      .rsp_rect_w,
      .rsp_rect_h,
      .rsp_status,
      .rsp_atlas_edge,
      .csr_wr_en,
      .csr_wr_data,
      .fail_count,
      .outstanding
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // recurring window where neither side idles
   function automatic bit calm_stretch();
      return ((cycles / 1500) % 5) == 3;
   endfunction

   // offer one item after a random gap and hold it until accepted
   task automatic offer_glyph(input logic [GLYPH_W-1:0] gw, input logic [GLYPH_W-1:0] gh);
      int unsigned r, gap;
      r = $urandom_range(99);
      if (calm_stretch() || r < 60)
         gap = 0;
      else if (r < 90)
         gap = $urandom_range(1, 3);
      else if (r < 98)
         gap = $urandom_range(4, 12);
      else
         gap = $urandom_range(30, 80);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_glyph_width  <= gw;
      req_glyph_height <= gh;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // drop valid and wait for every predicted item to come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // receiver: random stall bursts, one long hold-off once the sender is well in
   initial begin
      int unsigned r, span;
      bit          held_long;
      logic        stall_next;
      held_long = 1'b0;
      forever begin
         @(negedge clock);
         r = $urandom_range(99);
         if (!held_long && items_sent >= PRESSURE_AT) begin
            // fill the block until it stalls its input
            stall_next = 1'b1;
            span       = PRESSURE_CYCLES;
            held_long  = 1'b1;
         end else if (calm_stretch() || r < 65) begin
            stall_next = 1'b0;
            span       = $urandom_range(1, 6);
         end else if (r < 94) begin
            stall_next = 1'b1;
            span       = $urandom_range(1, 3);
         end else begin
            stall_next = 1'b1;
            span       = $urandom_range(15, 60);
         end
         rsp_stall <= stall_next;
         repeat (span - 1) @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      int unsigned        r, base;
      logic [GLYPH_W-1:0] gw, gh;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // opening items run at the reset growth limit
      for (int i = 15; i >= 0; i--)
         offer_glyph(OPENING[i][2*GLYPH_W-1:GLYPH_W], OPENING[i][GLYPH_W-1:0]);

      for (int p = 0; p < 5; p++) begin
         // limit changes only with the block idle
         drain_results();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= PHASE_LIMIT[p];
         @(negedge clock);
         csr_wr_en <= 1'b0;

         repeat (PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 78) begin
               // text-like run: a few font heights that keep reusing shelves
               base = 6 * $urandom_range(1, 8);
               gh   = GLYPH_W'(base - $urandom_range(base / 4));
               gw   = GLYPH_W'($urandom_range(1, base + 8));
            end else if (r < 88) begin
               // wide or tall glyphs that open shelves and grow the atlas
               gw = GLYPH_W'($urandom_range(1, 4095));
               gh = GLYPH_W'($urandom_range(1, 600));
            end else if (r < 94) begin
               gw = GLYPH_W'($urandom_range(0, 4095));
               gh = GLYPH_W'($urandom_range(0, 4095));
            end else begin
               gw = CORNER_SIZE[2'($urandom_range(3))];
               gh = CORNER_SIZE[2'($urandom_range(3))];
            end
            offer_glyph(gw, gh);
         end
      end

      drain_results();
      // catch any stray item after the last expected one
      repeat (END_SETTLE) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
